// ===== sv/bfe_pkg.sv =====
package bfe_pkg;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LEN_ERR  = 2'd1,
    ST_NO_FRAME = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    JOB_LEN_ERR  = 2'd0,
    JOB_NO_FRAME = 2'd1,
    JOB_HEADER   = 2'd2,
    JOB_DATA     = 2'd3
  } job_kind_e;

  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [2:0] STEP_SYNC_ONE = 3'd0;
  localparam logic [2:0] STEP_SYNC_TWO = 3'd1;
  localparam logic [2:0] STEP_CLASS    = 3'd2;
  localparam logic [2:0] STEP_ID       = 3'd3;
  localparam logic [2:0] STEP_LEN_LO   = 3'd4;
  localparam logic [2:0] STEP_LEN_HI   = 3'd5;
  localparam logic [2:0] STEP_HDR_CK_A = 3'd6;
  localparam logic [2:0] STEP_HDR_CK_B = 3'd7;
  localparam logic [2:0] STEP_DATA     = 3'd0;
  localparam logic [2:0] STEP_DAT_CK_A = 3'd1;
  localparam logic [2:0] STEP_DAT_CK_B = 3'd2;

  typedef struct packed {
    job_kind_e  kind;
    logic       with_ck;
    logic [7:0] msg_class;
    logic [7:0] msg_id;
    logic [7:0] len_lo;
    logic [7:0] len_hi;
    logic [7:0] data;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
  } job_t;

  // Sums are packed as {sum_b, sum_a}.
  function automatic logic [15:0] fl_add(logic [15:0] sums, logic [7:0] b);
    logic [7:0] a_n;
    logic [7:0] b_n;
    a_n = (sums[7:0] + b) & BYTE_MASK;
    b_n = (sums[15:8] + a_n) & BYTE_MASK;
    return {b_n, a_n};
  endfunction

endpackage

// ===== sv/bfe_if.sv =====
interface bfe_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, command, msg_class, msg_id, payload_length, data_byte,
                  input ready);
  modport sink (input valid, command, msg_class, msg_id, payload_length, data_byte,
                output ready);
endinterface

interface bfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic       run_last;
  logic [1:0] status;

  modport source (output valid, frame_byte, frame_end, run_last, status, input ready);
  modport sink (input valid, frame_byte, frame_end, run_last, status, output ready);
endinterface

// ===== sv/bfe_front.sv =====
module bfe_front import bfe_pkg::*; #(
  parameter int unsigned MaxPayload = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfe_in_if.sink      in_i,
  input  logic        full_i,
  output logic        push_o,
  output job_t        job_o
);

  localparam logic [15:0] MaxLen = 16'(MaxPayload);

  logic        open_q, open_d;
  logic [15:0] left_q, left_d;
  logic [15:0] sums_q, sums_d;
  logic [15:0] hdr_s1, hdr_s2, hdr_s3, hdr_s4;
  logic [15:0] dat_s;
  logic        accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept;

  always_comb begin
    hdr_s1 = fl_add(16'h0000, in_i.msg_class);
    hdr_s2 = fl_add(hdr_s1, in_i.msg_id);
    hdr_s3 = fl_add(hdr_s2, in_i.payload_length[7:0]);
    hdr_s4 = fl_add(hdr_s3, in_i.payload_length[15:8]);
    dat_s  = fl_add(sums_q, in_i.data_byte);
  end

  always_comb begin
    open_d            = open_q;
    left_d            = left_q;
    sums_d            = sums_q;
    job_o.kind        = JOB_NO_FRAME;
    job_o.with_ck     = 1'b0;
    job_o.msg_class   = in_i.msg_class;
    job_o.msg_id      = in_i.msg_id;
    job_o.len_lo      = in_i.payload_length[7:0];
    job_o.len_hi      = in_i.payload_length[15:8];
    job_o.data        = in_i.data_byte;
    job_o.ck_a        = hdr_s4[7:0];
    job_o.ck_b        = hdr_s4[15:8];
    if (in_i.command == CMD_START) begin
      if (in_i.payload_length > MaxLen) begin
        job_o.kind = JOB_LEN_ERR;
        open_d     = 1'b0;
        left_d     = '0;
        sums_d     = '0;
      end else begin
        job_o.kind    = JOB_HEADER;
        job_o.with_ck = (in_i.payload_length == 16'd0);
        if (in_i.payload_length == 16'd0) begin
          open_d = 1'b0;
          left_d = '0;
          sums_d = '0;
        end else begin
          open_d = 1'b1;
          left_d = in_i.payload_length;
          sums_d = hdr_s4;
        end
      end
    end else if (open_q) begin
      job_o.kind = JOB_DATA;
      job_o.ck_a = dat_s[7:0];
      job_o.ck_b = dat_s[15:8];
      if (left_q == 16'd1) begin
        job_o.with_ck = 1'b1;
        open_d        = 1'b0;
        left_d        = '0;
        sums_d        = '0;
      end else begin
        left_d = left_q - 16'd1;
        sums_d = dat_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
      sums_q <= '0;
    end else if (accept) begin
      open_q <= open_d;
      left_q <= left_d;
      sums_q <= sums_d;
    end
  end

endmodule

// ===== sv/bfe_queue.sv =====
module bfe_queue import bfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t job_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  job_t            slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign job_o   = slots_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== sv/bfe_back.sv =====
module bfe_back import bfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  bfe_out_if.source out_o
);

  logic       valid_q, valid_d;
  logic [2:0] step_q, step_d;
  logic [2:0] step_end;
  logic       advance;
  logic [7:0] res_byte;
  logic       res_end;
  logic       res_last;
  status_e    res_status;
  logic [7:0] byte_q;
  logic       end_q;
  logic       last_q;
  status_e    status_q;

  assign advance = !valid_q || out_o.ready;

  always_comb begin
    res_byte   = 8'h00;
    res_end    = 1'b0;
    res_status = ST_OK;
    step_end   = 3'd0;
    case (job_i.kind)
      JOB_LEN_ERR: begin
        res_status = ST_LEN_ERR;
      end
      JOB_NO_FRAME: begin
        res_status = ST_NO_FRAME;
      end
      JOB_HEADER: begin
        step_end = job_i.with_ck ? STEP_HDR_CK_B : STEP_LEN_HI;
        case (step_q)
          STEP_SYNC_ONE: res_byte = SYNC_ONE;
          STEP_SYNC_TWO: res_byte = SYNC_TWO;
          STEP_CLASS:    res_byte = job_i.msg_class;
          STEP_ID:       res_byte = job_i.msg_id;
          STEP_LEN_LO:   res_byte = job_i.len_lo;
          STEP_LEN_HI:   res_byte = job_i.len_hi;
          STEP_HDR_CK_A: res_byte = job_i.ck_a;
          STEP_HDR_CK_B: begin
            res_byte = job_i.ck_b;
            res_end  = 1'b1;
          end
          default:       res_byte = 8'h00;
        endcase
      end
      JOB_DATA: begin
        step_end = job_i.with_ck ? STEP_DAT_CK_B : STEP_DATA;
        case (step_q)
          STEP_DATA:     res_byte = job_i.data;
          STEP_DAT_CK_A: res_byte = job_i.ck_a;
          STEP_DAT_CK_B: begin
            res_byte = job_i.ck_b;
            res_end  = 1'b1;
          end
          default:       res_byte = 8'h00;
        endcase
      end
      default: res_status = ST_OK;
    endcase
    res_last = (step_q == step_end);
  end

  always_comb begin
    valid_d = valid_q;
    step_d  = step_q;
    pop_o   = 1'b0;
    if (advance) begin
      valid_d = job_valid_i;
      if (job_valid_i) begin
        if (res_last) begin
          pop_o  = 1'b1;
          step_d = 3'd0;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      valid_q <= valid_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && job_valid_i) begin
      byte_q   <= res_byte;
      end_q    <= res_end;
      last_q   <= res_last;
      status_q <= res_status;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.frame_byte = byte_q;
  assign out_o.frame_end  = end_q;
  assign out_o.run_last   = last_q;
  assign out_o.status     = status_q;

endmodule

// ===== sv/binary_frame_encoder_fletcher8_top.sv =====
// Channel   Direction  Handshake        Payload
// in_i      sink       valid / ready    command, msg_class, msg_id, payload_length, data_byte
// out_o     source     valid / ready    frame_byte, frame_end, run_last, status
//
// An item is taken in every cycle while the job queue (four entries) has room.
// Results leave the output register one per cycle unless out_o stalls: a start item
// gives 6 or 8 of them, a payload item 1 or 3, an error 1, so the output register sets
// the sustained rate. Reset clears the frame state, the queue and the output valid at once.
// A stall on the output fills the queue; the input stalls only once the queue is full.
module binary_frame_encoder_fletcher8_top import bfe_pkg::*; #(
  parameter int unsigned MaxPayload = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfe_in_if.sink    in_i,
  bfe_out_if.source out_o
);

  logic push;
  logic full;
  logic job_valid;
  logic pop;
  job_t push_job;
  job_t head_job;

  bfe_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .job_o (push_job)
  );

  bfe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .full_o (full),
    .valid_o(job_valid),
    .pop_i  (pop),
    .job_o  (head_job)
  );

  bfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

// ===== sv/bfe_checker.sv =====
module bfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] frame_byte_i,
  input logic       frame_end_i,
  input logic       run_last_i,
  input logic [1:0] status_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_byte_i) &&
                                    $stable(run_last_i))
    else $error("Stalled result item changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> run_last_i && status_i == 2'd0)
    else $error("Frame end on an item that does not close its run.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != 2'd0 |-> frame_byte_i == 8'h00 && run_last_i && !frame_end_i)
    else $error("Error item carries frame data.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && frame_end_i |=> !out_valid_i || !frame_end_i)
    else $error("Two frame ends in a row.");

endmodule

bind binary_frame_encoder_fletcher8_top bfe_checker u_bfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .frame_byte_i(out_o.frame_byte),
  .frame_end_i (out_o.frame_end),
  .run_last_i  (out_o.run_last),
  .status_i    (out_o.status)
);

// ===== bench/tb_binary_frame_encoder_fletcher8_top.sv =====
`timescale 1ns / 1ps

module tb_binary_frame_encoder_fletcher8_top;
  import bfe_pkg::*;

  localparam int MAX_LEN      = 512;
  localparam int RANDOM_ITEMS = 90;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       run_last;
    status_e    status;
  } frame_res_t;

  logic clk_i;
  logic rst_ni;

  bfe_in_if  in_bus ();
  bfe_out_if out_bus ();

  binary_frame_encoder_fletcher8_top #(
    .MaxPayload(MAX_LEN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  frame_res_t frame_q[$];
  int         mismatch_cnt = 0;
  bit         in_idle = 1'b1;
  bit         out_idle = 1'b1;

  logic        open_r = 1'b0;
  logic [15:0] left_r = '0;
  logic [7:0]  ck_a_r = '0;
  logic [7:0]  ck_b_r = '0;

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void add_result(logic [7:0] b, logic e, logic l, status_e s);
    frame_res_t r;
    r.frame_byte = b;
    r.frame_end  = e;
    r.run_last   = l;
    r.status     = s;
    frame_q.push_back(r);
  endfunction

  function automatic void fold_byte(logic [7:0] b);
    ck_a_r = ck_a_r + b;
    ck_b_r = ck_b_r + ck_a_r;
  endfunction

  function automatic void clear_frame();
    open_r = 1'b0;
    left_r = '0;
    ck_a_r = '0;
    ck_b_r = '0;
  endfunction

  function automatic void close_frame();
    add_result(ck_a_r, 1'b0, 1'b0, ST_OK);
    add_result(ck_b_r, 1'b1, 1'b1, ST_OK);
    clear_frame();
  endfunction

  // Works out the bytes that one accepted item must produce.
  function automatic void encode_item(cmd_e cmd, logic [7:0] cls, logic [7:0] id,
                                      logic [15:0] len, logic [7:0] data);
    if (cmd == CMD_START) begin
      clear_frame();
      if (len > MAX_LEN) begin
        add_result(8'h00, 1'b0, 1'b1, ST_LEN_ERR);
        return;
      end
      add_result(SYNC_ONE, 1'b0, 1'b0, ST_OK);
      add_result(SYNC_TWO, 1'b0, 1'b0, ST_OK);
      add_result(cls, 1'b0, 1'b0, ST_OK);
      add_result(id, 1'b0, 1'b0, ST_OK);
      add_result(len[7:0], 1'b0, 1'b0, ST_OK);
      add_result(len[15:8], 1'b0, len != 16'd0, ST_OK);
      fold_byte(cls);
      fold_byte(id);
      fold_byte(len[7:0]);
      fold_byte(len[15:8]);
      if (len == 16'd0) begin
        close_frame();
      end else begin
        open_r = 1'b1;
        left_r = len;
      end
    end else if (!open_r) begin
      add_result(8'h00, 1'b0, 1'b1, ST_NO_FRAME);
    end else begin
      fold_byte(data);
      left_r = left_r - 16'd1;
      if (left_r == 16'd0) begin
        add_result(data, 1'b0, 1'b0, ST_OK);
        close_frame();
      end else begin
        add_result(data, 1'b0, 1'b1, ST_OK);
      end
    end
  endfunction

  task automatic send_item(cmd_e cmd, logic [7:0] cls, logic [7:0] id,
                           logic [15:0] len, logic [7:0] data);
    int gap;
    gap = in_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid          <= 1'b1;
    in_bus.command        <= cmd;
    in_bus.msg_class      <= cls;
    in_bus.msg_id         <= id;
    in_bus.payload_length <= len;
    in_bus.data_byte      <= data;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    encode_item(cmd, cls, id, len, data);
  endtask

  // The fields that a command does not use carry random values throughout.
  task automatic send_start(logic [7:0] cls, logic [7:0] id, logic [15:0] len);
    send_item(CMD_START, cls, id, len, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_data(logic [7:0] data);
    send_item(CMD_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 65535)), data);
  endtask

  task automatic test_stray_payload();
    send_data(8'hFF);
    send_data(8'h00);
  endtask

  task automatic test_empty_frames();
    send_start(8'hFF, 8'h00, 16'd0);
    send_start(8'h00, 8'hFF, 16'd0);
  endtask

  task automatic test_length_errors();
    send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(MAX_LEN + 1));
    send_start(8'hFF, 8'hFF, 16'hFFFF);
    send_data(8'hA5);
  endtask

  task automatic test_short_frames();
    send_start(8'h01, 8'h02, 16'd1);
    send_data(8'hFF);
    send_data(8'h5A);
    send_start(8'h06, 8'h8F, 16'd2);
    send_data(8'h80);
    send_data(8'h7F);
  endtask

  task automatic test_abandoned_frames();
    send_start(8'h0A, 8'h04, 16'd3);
    send_data(8'h11);
    send_start(8'h0A, 8'h05, 16'd0);
    send_start(8'h05, 8'h01, 16'd4);
    send_data(8'h22);
    send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'h0300);
    send_data(8'h33);
  endtask

  // The largest length that is accepted opens a frame; a few bytes follow
  // before a short frame takes its place.
  task automatic test_max_length();
    in_idle  = $urandom_range(0, 1);
    out_idle = $urandom_range(0, 1);
    send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(MAX_LEN));
    repeat (3) send_data(8'($urandom_range(0, 255)));
    send_start(8'h10, 8'h20, 16'd1);
    send_data(8'hC3);
  endtask

  // Mostly complete frames of random content, with truncated frames, stray
  // payload bytes and oversized lengths mixed in.
  task automatic test_random_frames();
    int sent;
    int kind;
    int len;
    int cut;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      in_idle  = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len));
        repeat (len) send_data(8'($urandom_range(0, 255)));
        sent += len + 1;
      end else if (kind == 7) begin
        len = $urandom_range(2, 10);
        cut = $urandom_range(1, len - 1);
        send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len));
        repeat (cut) send_data(8'($urandom_range(0, 255)));
        sent += cut + 1;
      end else if (kind == 8) begin
        cut = $urandom_range(1, 3);
        repeat (cut) send_data(8'($urandom_range(0, 255)));
        sent += cut;
      end else begin
        send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(MAX_LEN + 1, 65535)));
        sent += 1;
      end
    end
  endtask

  initial begin : out_ready_drive
    int stall;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = out_idle ? $urandom_range(0, 16) : 0;
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid === 1'b1 && out_bus.ready === 1'b1));
    end
  end

  always @(posedge clk_i) begin : check_result
    frame_res_t got;
    frame_res_t want;
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.frame_byte = out_bus.frame_byte;
      got.frame_end  = out_bus.frame_end;
      got.run_last   = out_bus.run_last;
      got.status     = status_e'(out_bus.status);
      if (frame_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: unexpected item: byte %h end %b last %b status %0d",
                   $time, got.frame_byte, got.frame_end, got.run_last, got.status);
      end else begin
        want = frame_q.pop_front();
        if (got.frame_byte !== want.frame_byte || got.frame_end !== want.frame_end ||
            got.run_last !== want.run_last || got.status !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: expected byte %h end %b last %b status %0d,",
                     $time, want.frame_byte, want.frame_end, want.run_last, want.status,
                     " got byte %h end %b last %b status %0d",
                     got.frame_byte, got.frame_end, got.run_last, got.status);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_binary_frame_encoder_fletcher8_top: FAIL");
    $finish;
  end

  initial begin
    rst_ni                <= 1'b0;
    in_bus.valid          <= 1'b0;
    in_bus.command        <= CMD_START;
    in_bus.msg_class      <= '0;
    in_bus.msg_id         <= '0;
    in_bus.payload_length <= '0;
    in_bus.data_byte      <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stray_payload();
    test_empty_frames();
    test_length_errors();
    test_short_frames();
    test_abandoned_frames();
    test_max_length();
    test_random_frames();

    in_bus.valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && frame_q.size() == 0) begin
      $display("tb_binary_frame_encoder_fletcher8_top: PASS");
    end else begin
      $display("tb_binary_frame_encoder_fletcher8_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bfe_pkg.sv
sv/bfe_if.sv
sv/bfe_front.sv
sv/bfe_queue.sv
sv/bfe_back.sv
sv/binary_frame_encoder_fletcher8_top.sv
sv/bfe_checker.sv
bench/tb_binary_frame_encoder_fletcher8_top.sv
